/* hdl/u16550_pkg.sv */
// ----------------------------------------------------------------------------
// u16550_pkg
// Types and constants shared by the 16550-style register block.
// ----------------------------------------------------------------------------
`default_nettype none

package u16550_pkg;

  // request kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // register offsets
  localparam logic [2:0] ADDR_DATA = 3'd0;  // RBR/THR, DLL with DLAB
  localparam logic [2:0] ADDR_IER  = 3'd1;  // IER, DLM with DLAB
  localparam logic [2:0] ADDR_IIR  = 3'd2;  // IIR on read, FCR on write
  localparam logic [2:0] ADDR_LCR  = 3'd3;
  localparam logic [2:0] ADDR_MCR  = 3'd4;
  localparam logic [2:0] ADDR_LSR  = 3'd5;
  localparam logic [2:0] ADDR_MSR  = 3'd6;
  localparam logic [2:0] ADDR_SCR  = 3'd7;

  // interrupt identification codes
  localparam logic [3:0] IIR_CTI  = 4'hC;
  localparam logic [3:0] IIR_THRI = 4'h2;
  localparam logic [3:0] IIR_MSI  = 4'h0;
  localparam logic [3:0] IIR_NONE = 4'h1;

  // pending flag bit positions
  localparam int PEND_MSI  = 0;
  localparam int PEND_THRI = 1;
  localparam int PEND_CTI  = 2;

  // IER bit positions
  localparam int IER_RX  = 0;
  localparam int IER_TX  = 1;
  localparam int IER_MS  = 3;

  localparam int LCR_DLAB    = 7;
  localparam int FCR_RX_CLR  = 1;

  localparam logic [7:0] LCR_RESET  = 8'h03;
  localparam logic [7:0] IIR_FIXED  = 8'hC0;
  // THRE/TEMT never drop, modem status low nibble never sets
  localparam logic [7:0] LSR_FIXED  = 8'h60;
  localparam logic [7:0] MSR_VALUE  = 8'hB0;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } u16550_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       bad_register;
  } u16550_out_t;

  // result of one request before the FIFO read data is merged in
  typedef struct packed {
    u16550_out_t res;
    logic        pop_hit;
  } u16550_stg_t;

  function automatic logic [3:0] iir_code(input logic [2:0] pend, input logic [3:0] ier);
    logic [3:0] code;
    begin
      if (pend[PEND_CTI] && ier[IER_RX]) begin
        code = IIR_CTI;
      end else if (pend[PEND_THRI] && ier[IER_TX]) begin
        code = IIR_THRI;
      end else if (pend[PEND_MSI] && ier[IER_MS]) begin
        code = IIR_MSI;
      end else begin
        code = IIR_NONE;
      end
      return code;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/u16550_rxmem.sv */
// ----------------------------------------------------------------------------
// u16550_rxmem
// Receive FIFO storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module u16550_rxmem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/u16550_regs.sv */
// ----------------------------------------------------------------------------
// u16550_regs
// Register file, decode and FIFO pointers; drives the receive store.
// ----------------------------------------------------------------------------
`default_nettype none

module u16550_regs import u16550_pkg::*; #(
  parameter int RX_DEPTH = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_acc,
  input  wire u16550_in_t    req,
  output u16550_stg_t        stg,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [7:0]         mem_wr_data,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr
);

  logic [7:0]    lcr_r, lcr_nxt;
  logic [3:0]    ier_r, ier_nxt;
  logic [2:0]    pend_r, pend_nxt;
  logic [7:0]    dll_r, dll_nxt;
  logic [7:0]    dlm_r, dlm_nxt;
  logic          dr_r, dr_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [AW-1:0] head_inc, tail_inc;
  logic [3:0]    ident;
  logic          dlab;
  logic          full;
  logic          push;

  assign head_inc = (head_r == AW'(RX_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_inc = (tail_r == AW'(RX_DEPTH - 1)) ? '0 : tail_r + AW'(1);
  assign ident    = iir_code(pend_r, ier_r);
  assign dlab     = lcr_r[LCR_DLAB];
  assign full     = (cnt_r == CW'(RX_DEPTH));

  always_comb begin
    lcr_nxt  = lcr_r;
    ier_nxt  = ier_r;
    pend_nxt = pend_r;
    dll_nxt  = dll_r;
    dlm_nxt  = dlm_r;
    dr_nxt   = dr_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    stg      = '0;
    push     = 1'b0;

    unique case (req.req_type)
      REQ_READ: begin
        if (dlab && req.reg_addr == ADDR_DATA) begin
          stg.res.read_data = dll_r;
        end else if (dlab && req.reg_addr == ADDR_IER) begin
          stg.res.read_data = dlm_r;
        end else begin
          unique case (req.reg_addr)
            ADDR_DATA: begin
              if (cnt_r != '0) begin
                stg.pop_hit = 1'b1;
                head_nxt    = head_inc;
                cnt_nxt     = cnt_r - CW'(1);
              end
              // empty afterwards (or already): drop data ready, ack timeout
              if (cnt_nxt == '0) begin
                dr_nxt             = 1'b0;
                pend_nxt[PEND_CTI] = 1'b0;
              end
            end
            ADDR_IER: stg.res.read_data = {4'h0, ier_r};
            ADDR_IIR: begin
              stg.res.read_data = {4'h0, ident} | IIR_FIXED;
              if (ident == IIR_THRI) begin
                pend_nxt[PEND_THRI] = 1'b0;
              end
            end
            ADDR_LCR: stg.res.read_data = lcr_r;
            ADDR_LSR: stg.res.read_data = LSR_FIXED | {7'h00, dr_r};
            ADDR_MSR: stg.res.read_data = MSR_VALUE;
            ADDR_MCR, ADDR_SCR: stg.res.bad_register = 1'b1;
            default: stg.res.bad_register = 1'b1;
          endcase
        end
      end
      REQ_WRITE: begin
        if (dlab && req.reg_addr == ADDR_DATA) begin
          dll_nxt = req.write_data;
        end else if (dlab && req.reg_addr == ADDR_IER) begin
          dlm_nxt = req.write_data;
        end else begin
          unique case (req.reg_addr)
            ADDR_DATA: begin
              stg.res.tx_valid    = 1'b1;
              stg.res.tx_byte     = req.write_data;
              pend_nxt[PEND_THRI] = 1'b1;
            end
            ADDR_IER: ier_nxt = req.write_data[3:0];
            ADDR_IIR: begin
              // FCR: only the receive clear has an effect
              if (req.write_data[FCR_RX_CLR]) begin
                pend_nxt[PEND_CTI] = 1'b0;
                head_nxt           = '0;
                tail_nxt           = '0;
                cnt_nxt            = '0;
              end
            end
            ADDR_LCR: lcr_nxt = req.write_data;
            ADDR_MCR: ;
            ADDR_LSR, ADDR_MSR, ADDR_SCR: stg.res.bad_register = 1'b1;
            default: stg.res.bad_register = 1'b1;
          endcase
        end
      end
      REQ_RX: begin
        if (!full) begin
          push     = 1'b1;
          tail_nxt = tail_inc;
          cnt_nxt  = cnt_r + CW'(1);
        end
        // raised even when the byte is dropped
        dr_nxt             = 1'b1;
        pend_nxt[PEND_CTI] = 1'b1;
      end
      REQ_NONE: ;
      default: ;
    endcase

    stg.res.irq = (iir_code(pend_nxt, ier_nxt) != IIR_NONE);
  end

  assign mem_wr_en   = req_acc && push;
  assign mem_wr_addr = tail_r;
  assign mem_wr_data = req.rx_byte;
  assign mem_rd_en   = req_acc && stg.pop_hit;
  assign mem_rd_addr = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r  <= LCR_RESET;
      ier_r  <= '0;
      pend_r <= '0;
      dll_r  <= '0;
      dlm_r  <= '0;
      dr_r   <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (req_acc) begin
      lcr_r  <= lcr_nxt;
      ier_r  <= ier_nxt;
      pend_r <= pend_nxt;
      dll_r  <= dll_nxt;
      dlm_r  <= dlm_nxt;
      dr_r   <= dr_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RX_DEPTH))
    else $error("rx count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc && req.req_type == REQ_RX && full |=> $stable(cnt_r) && $stable(tail_r))
    else $error("push into full fifo changed pointers");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> cnt_r != '0)
    else $error("store read with empty fifo");

  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("push and pop in one request");

endmodule

`default_nettype wire

/* hdl/uart_16550_register_model_core.sv */
// ----------------------------------------------------------------------------
// uart_16550_register_model_core
// 16550-style UART register block with a receive FIFO held in block memory.
// ----------------------------------------------------------------------------
// Each input request is a bus read, a bus write or a byte from the line; each
// produces exactly one result carrying read data, a transmitted byte, the
// interrupt level after the request and an unsupported-register flag.
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low.
// A taken request passes through the stage register and then the output
// register. The FIFO memory read happens on the accepting edge, alongside
// the stage register, and the output register loads when the stage moves on.
// Throughput: one request per cycle while in_stall is low; registers and FIFO
// pointers are updated as the request is taken, and the memory read of a pop
// is retired in the following stage.
// Stall: the output register and the stage behind it hold two results; while
// out_stall is high and both are full, in_stall is raised.
// Reset (rst_n low, synchronous) returns LCR to 0x03, clears IER, the pending
// flags, the divisor and empties the FIFO. The FIFO storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_16550_register_model_core import u16550_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire u16550_in_t  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output u16550_out_t      out_data
);

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW = $clog2(RX_DEPTH + 1);

  u16550_stg_t   stg;
  u16550_stg_t   s1_stg_r;
  u16550_out_t   out_r, out_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          out_v_r, out_v_nxt;
  logic          s1_adv;
  logic          in_acc;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  u16550_regs #(
    .RX_DEPTH (RX_DEPTH),
    .AW       (AW),
    .CW       (CW)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_acc     (in_acc),
    .req         (in_data),
    .stg         (stg),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr)
  );

  u16550_rxmem #(
    .DEPTH (RX_DEPTH),
    .AW    (AW)
  ) u_rxmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // stage 1 moves on when the output register is free or being emptied
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);
  assign out_v_nxt = s1_adv || (out_v_r && out_stall);

  always_comb begin
    out_nxt = s1_stg_r.res;
    if (s1_stg_r.pop_hit) begin
      out_nxt.read_data = mem_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stg_r <= stg;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_pop_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && stg.pop_hit |=> s1_v_r && s1_stg_r.pop_hit)
    else $error("pop request lost its read flag");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && out_v_r && out_stall)
    else $error("input stalled with room in pipeline");

  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r)
    else $error("advanced request not shown at output");

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_stg_r.pop_hit && !s1_adv |=> $stable(mem_rd_data))
    else $error("fifo read data changed under a held pop");

endmodule

`default_nettype wire
